>>> rtl/psc_pkg.sv
// Package: payload types, sizes and register codes of the pixel stack combiner.
package psc_pkg;

  localparam int unsigned MaxFrames  = 32;
  localparam int unsigned ClipPasses = 2;
  localparam int unsigned IdxW  = $clog2(MaxFrames);
  localparam int unsigned CntW  = $clog2(MaxFrames + 1);
  localparam int unsigned PassW = $clog2(ClipPasses + 1);

  // Accumulator and divider widths
  localparam int unsigned SwW   = 16 + CntW - 1;          // sum of weights
  localparam int unsigned SwvW  = 32 + CntW - 1;          // sum of weight * sample
  localparam int unsigned SqW   = 48 + CntW - 1;          // sum of squared deviations
  localparam int unsigned DivW  = (SqW > SwvW + 8) ? SqW : SwvW + 8;
  localparam int unsigned SqrtW = DivW + (DivW % 2);
  localparam int unsigned DivCntW = $clog2(DivW + 1);
  localparam int unsigned DevW  = SqrtW / 2;
  localparam int unsigned LimW  = 12 + DevW;

  typedef enum logic [1:0] {
    CfgMethod  = 2'd0,
    CfgSigma   = 2'd1,
    CfgWeights = 2'd2,
    CfgNone    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MethodMean   = 2'd0,
    MethodMedian = 2'd1,
    MethodClip   = 2'd2,
    MethodClipAlt = 2'd3
  } method_e;

  typedef struct packed {
    logic [15:0] sample;
    logic [15:0] frame_weight;
    logic        last_sample;
  } in_t;

  typedef struct packed {
    logic [23:0] pixel_value;
    logic [5:0]  kept_count;
    logic        overflow;
  } out_t;

  typedef struct packed {
    logic [15:0] sample;
    logic [15:0] weight;
  } entry_t;

endpackage

>>> rtl/pixel_stack_combiner_core.sv
// Top level: stack store, sequencer and shared divider / root unit of the pixel combiner.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------
//  in      | input     | in_valid_i / in_ready_o   | in_data_i  (psc_pkg::in_t)
//  out     | output    | out_valid_o / out_ready_i | out_data_o (psc_pkg::out_t)
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A sample that does not close the stack is a single memory write.
// A closing sample starts the sequencer; every walk over the store goes through
// the single read port.
// Reset clears counts, mask and registers; the store itself is never cleared.
// Input stalls while the sequencer runs; a result waiting on out does not block
// loading of the next stack.
module pixel_stack_combiner_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  psc_pkg::in_t       in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output psc_pkg::out_t      out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [11:0]        cfg_data_i
);
  import psc_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StPassChk, StMeanWalk, StMeanDiv, StSqWalk, StSqDiv, StSqrt,
    StRejWalk, StMedRd, StMedCap, StMedWalk, StFin
  } state_e;

  state_e               state_q;
  logic [1:0]           method_q;
  logic [11:0]          sigma_q;
  logic                 use_w_q;

  entry_t               mem [MaxFrames];
  entry_t               rd_q;
  logic [IdxW-1:0]      rd_addr;

  logic [MaxFrames-1:0] keep_q;
  logic [CntW-1:0]      count_q, count_d;
  logic                 ovf_q;
  logic [CntW-1:0]      kept_q;
  logic [PassW-1:0]     pass_q;
  logic                 final_q;

  logic [CntW-1:0]      idx_q;
  logic                 rd_vld_q;
  logic [IdxW-1:0]      rd_idx_q;
  logic                 walk_issue, walk_done, walking;

  logic [SwW-1:0]       sw_q;
  logic [SwvW-1:0]      swv_q;
  logic [SqW-1:0]       sq_q;
  logic [23:0]          mean_q;
  logic [DevW-1:0]      dev_q;
  logic [23:0]          val_q;

  logic [DivW-1:0]      num_q, quo_q;
  logic [SwW-1:0]       den_q;
  logic [SwW-1:0]       rem_q;
  logic [DivCntW-1:0]   dcnt_q;
  logic [SwW:0]         rem_sh;

  logic [SqrtW-1:0]     x_q, res_q, bit_q, rb_sum;

  logic [IdxW-1:0]      med_i_q;
  logic [15:0]          cand_q;
  logic [CntW-1:0]      less_q, eq_q;
  logic [CntW:0]        le_sum;

  logic [15:0]          w_eff;
  logic [23:0]          v256, dabs;
  logic [31:0]          wv_prod;
  logic [47:0]          dsq;
  logic [LimW-1:0]      lim;
  logic                 out_valid_q;
  out_t                 out_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign count_d = (count_q < CntW'(MaxFrames)) ? count_q + 1'b1 : count_q;

  // Walk control: one read issued per cycle, data in the next cycle
  assign walking    = (state_q == StMeanWalk) || (state_q == StSqWalk) ||
                      (state_q == StRejWalk) || (state_q == StMedWalk);
  assign walk_issue = walking && (idx_q < count_q);
  assign walk_done  = walking && (idx_q == count_q) && !rd_vld_q;
  assign rd_addr    = (state_q == StMedRd) ? med_i_q : idx_q[IdxW-1:0];

  // Datapath terms of the entry read back
  assign w_eff   = use_w_q ? rd_q.weight : 16'd256;
  assign v256    = {rd_q.sample, 8'h00};
  assign dabs    = (v256 > mean_q) ? v256 - mean_q : mean_q - v256;
  assign wv_prod = w_eff * rd_q.sample;
  assign dsq     = dabs * dabs;
  assign lim     = LimW'(sigma_q) * LimW'(dev_q);
  assign rem_sh  = {rem_q, num_q[DivW-1]};
  assign rb_sum  = res_q + bit_q;
  assign le_sum  = {1'b0, less_q} + {1'b0, eq_q};

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o && (count_q < CntW'(MaxFrames))) begin
      mem[count_q[IdxW-1:0]] <= '{sample: in_data_i.sample, weight: in_data_i.frame_weight};
    end
    rd_q <= mem[rd_addr];
  end

  // Configuration, sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      method_q    <= MethodClip;
      sigma_q     <= 12'd768;
      use_w_q     <= 1'b0;
      keep_q      <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      kept_q      <= '0;
      pass_q      <= '0;
      final_q     <= 1'b0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      sw_q        <= '0;
      swv_q       <= '0;
      sq_q        <= '0;
      mean_q      <= '0;
      dev_q       <= '0;
      val_q       <= '0;
      num_q       <= '0;
      quo_q       <= '0;
      den_q       <= '0;
      rem_q       <= '0;
      dcnt_q      <= '0;
      x_q         <= '0;
      res_q       <= '0;
      bit_q       <= '0;
      med_i_q     <= '0;
      cand_q      <= '0;
      less_q      <= '0;
      eq_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Write configuration registers
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CfgMethod:  method_q <= cfg_data_i[1:0];
          CfgSigma:   sigma_q  <= cfg_data_i;
          CfgWeights: use_w_q  <= cfg_data_i[0];
          default:    ;
        endcase
      end

      // Drop the result once taken
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      // Track the read in flight
      rd_vld_q <= walk_issue;
      rd_idx_q <= idx_q[IdxW-1:0];
      if (walk_issue) idx_q <= idx_q + 1'b1;

      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            if (count_q < CntW'(MaxFrames)) begin
              keep_q[count_q[IdxW-1:0]] <= 1'b1;
              count_q <= count_d;
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_data_i.last_sample) begin
              kept_q  <= count_d;
              pass_q  <= '0;
              idx_q   <= '0;
              sw_q    <= '0;
              swv_q   <= '0;
              unique case (method_e'(method_q))
                MethodMean: begin
                  final_q <= 1'b1;
                  state_q <= StMeanWalk;
                end
                MethodMedian: begin
                  med_i_q <= '0;
                  state_q <= StMedRd;
                end
                default: begin
                  final_q <= 1'b0;
                  state_q <= StPassChk;
                end
              endcase
            end
          end
        end

        // Start a clip pass or the final mean
        StPassChk: begin
          idx_q <= '0;
          sw_q  <= '0;
          swv_q <= '0;
          if ((pass_q == PassW'(ClipPasses)) || (kept_q < CntW'(3))) final_q <= 1'b1;
          state_q <= StMeanWalk;
        end

        // Accumulate weights and weighted samples of kept entries
        StMeanWalk: begin
          if (rd_vld_q && keep_q[rd_idx_q]) begin
            sw_q  <= sw_q + SwW'(w_eff);
            swv_q <= swv_q + SwvW'(wv_prod);
          end
          if (walk_done) begin
            if (sw_q == '0) begin
              if (final_q) begin
                val_q   <= '0;
                state_q <= StFin;
              end else begin
                final_q <= 1'b1;
                idx_q   <= '0;
                state_q <= StMeanWalk;
              end
            end else begin
              num_q   <= DivW'({swv_q, 8'h00}) + DivW'(sw_q >> 1);
              den_q   <= sw_q;
              rem_q   <= '0;
              quo_q   <= '0;
              dcnt_q  <= DivCntW'(DivW);
              state_q <= StMeanDiv;
            end
          end
        end

        // Shared restoring divider, one quotient bit per cycle
        StMeanDiv, StSqDiv: begin
          if (dcnt_q != '0) begin
            num_q  <= num_q << 1;
            dcnt_q <= dcnt_q - 1'b1;
            if (rem_sh >= {1'b0, den_q}) begin
              rem_q <= SwW'(rem_sh - {1'b0, den_q});
              quo_q <= {quo_q[DivW-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh[SwW-1:0];
              quo_q <= {quo_q[DivW-2:0], 1'b0};
            end
          end else if (state_q == StMeanDiv) begin
            mean_q <= quo_q[23:0];
            if (final_q) begin
              val_q   <= quo_q[23:0];
              state_q <= StFin;
            end else begin
              idx_q   <= '0;
              sq_q    <= '0;
              state_q <= StSqWalk;
            end
          end else begin
            x_q     <= SqrtW'(quo_q);
            res_q   <= '0;
            bit_q   <= SqrtW'(1) << (SqrtW - 2);
            state_q <= StSqrt;
          end
        end

        // Sum squared deviations about the mean
        StSqWalk: begin
          if (rd_vld_q && keep_q[rd_idx_q]) sq_q <= sq_q + SqW'(dsq);
          if (walk_done) begin
            num_q   <= DivW'(sq_q);
            den_q   <= SwW'(kept_q);
            rem_q   <= '0;
            quo_q   <= '0;
            dcnt_q  <= DivCntW'(DivW);
            state_q <= StSqDiv;
          end
        end

        // Integer square root, two bits of radicand per cycle
        StSqrt: begin
          if (bit_q != '0) begin
            if (x_q >= rb_sum) begin
              x_q   <= x_q - rb_sum;
              res_q <= (res_q >> 1) + bit_q;
            end else begin
              res_q <= res_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end else begin
            dev_q <= res_q[DevW-1:0];
            idx_q <= '0;
            if (res_q == '0) begin
              final_q <= 1'b1;
              sw_q    <= '0;
              swv_q   <= '0;
              state_q <= StMeanWalk;
            end else begin
              state_q <= StRejWalk;
            end
          end
        end

        // Reject entries outside the clip width
        StRejWalk: begin
          if (rd_vld_q && keep_q[rd_idx_q] && (LimW'({dabs, 8'h00}) > lim)) begin
            keep_q[rd_idx_q] <= 1'b0;
            kept_q <= kept_q - 1'b1;
          end
          if (walk_done) begin
            pass_q  <= pass_q + 1'b1;
            state_q <= StPassChk;
          end
        end

        // Median: read a candidate, then rank it against every entry
        StMedRd: state_q <= StMedCap;

        StMedCap: begin
          cand_q  <= rd_q.sample;
          less_q  <= '0;
          eq_q    <= '0;
          idx_q   <= '0;
          state_q <= StMedWalk;
        end

        StMedWalk: begin
          if (rd_vld_q) begin
            if (rd_q.sample < cand_q) less_q <= less_q + 1'b1;
            else if (rd_q.sample == cand_q) eq_q <= eq_q + 1'b1;
          end
          if (walk_done) begin
            if ((less_q <= (count_q >> 1)) && ({1'b0, count_q >> 1} < le_sum)) begin
              val_q   <= {cand_q, 8'h00};
              state_q <= StFin;
            end else begin
              med_i_q <= med_i_q + 1'b1;
              state_q <= StMedRd;
            end
          end
        end

        // Hand over the result and open a new stack
        StFin: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q       <= 1'b1;
            out_q.pixel_value <= val_q;
            out_q.kept_count  <= 6'(kept_q);
            out_q.overflow    <= ovf_q;
            count_q           <= '0;
            ovf_q             <= 1'b0;
            keep_q            <= '0;
            state_q           <= StIdle;
          end
        end

        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

>>> tb/tb_top.sv
// Testbench of the pixel stack combiner: queued stimulus, predictor and result scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import psc_pkg::*;

  localparam int unsigned DrainCycles = 3000;
  localparam int unsigned WatchLimit  = 50000;
  localparam int unsigned LongHold    = 400;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  in_t           in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  out_t          out_data_o;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [1:0]    cfg_index_i;
  logic [11:0]   cfg_data_i;

  pixel_stack_combiner_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor state
  logic [1:0]  method_q;
  logic [11:0] sigma_q;
  logic        weights_on_q;
  logic [15:0] frame_px [MaxFrames];
  logic [15:0] frame_wt [MaxFrames];
  bit          keep_px  [MaxFrames];
  int unsigned stack_len;
  bit          dropped;

  in_t  pending_items[$];
  out_t expected_pixels[$];
  int   mismatches;
  bit   quiet;
  bit   long_hold_req;
  bit   in_fire;
  int   send_gap;
  int   recv_gap;
  int   hold_cnt;
  int   idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Weighted mean of kept samples, Q16.8
  function automatic longint unsigned kept_mean(output bit zero_w);
    longint unsigned sw, swv, w;
    sw = 0;
    swv = 0;
    for (int i = 0; i < stack_len; i++) begin
      if (keep_px[i]) begin
        w = weights_on_q ? longint'(frame_wt[i]) : 256;
        sw += w;
        swv += w * frame_px[i];
      end
    end
    zero_w = (sw == 0);
    if (sw == 0) return 0;
    return (swv * 256 + sw / 2) / sw;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned median_px();
    int unsigned rank, less, eq;
    rank = stack_len / 2;
    for (int i = 0; i < stack_len; i++) begin
      less = 0;
      eq = 0;
      for (int j = 0; j < stack_len; j++) begin
        if (frame_px[j] < frame_px[i]) less++;
        else if (frame_px[j] == frame_px[i]) eq++;
      end
      if (less <= rank && rank < less + eq) return longint'(frame_px[i]) << 8;
    end
    return 0;
  endfunction

  function automatic longint unsigned clipped_mean(output int unsigned kept);
    longint unsigned mean, sq, dev, lim, v, d;
    bit zw;
    kept = stack_len;
    for (int i = 0; i < stack_len; i++) keep_px[i] = 1;
    for (int p = 0; p < ClipPasses; p++) begin
      if (kept < 3) break;
      mean = kept_mean(zw);
      if (zw) break;
      sq = 0;
      for (int i = 0; i < stack_len; i++) begin
        if (keep_px[i]) begin
          v = longint'(frame_px[i]) << 8;
          d = v > mean ? v - mean : mean - v;
          sq += d * d;
        end
      end
      dev = int_sqrt(sq / kept);
      if (dev == 0) break;
      lim = longint'(sigma_q) * dev;
      for (int i = 0; i < stack_len; i++) begin
        if (keep_px[i]) begin
          v = longint'(frame_px[i]) << 8;
          d = v > mean ? v - mean : mean - v;
          if (d * 256 > lim) begin
            keep_px[i] = 0;
            kept--;
          end
        end
      end
    end
    return kept_mean(zw);
  endfunction

  // Load one item into the model stack; close the stack on a last sample
  task automatic combine_item(input in_t it);
    out_t res;
    longint unsigned val;
    int unsigned kept;
    bit zw;
    if (stack_len < MaxFrames) begin
      frame_px[stack_len] = it.sample;
      frame_wt[stack_len] = it.frame_weight;
      keep_px[stack_len] = 1;
      stack_len++;
    end else begin
      dropped = 1;
    end
    if (it.last_sample) begin
      if (method_q == MethodMean) begin
        for (int i = 0; i < stack_len; i++) keep_px[i] = 1;
        val = kept_mean(zw);
        kept = stack_len;
      end else if (method_q == MethodMedian) begin
        val = median_px();
        kept = stack_len;
      end else begin
        val = clipped_mean(kept);
      end
      res.pixel_value = val[23:0];
      res.kept_count = kept[5:0];
      res.overflow = dropped;
      expected_pixels = {expected_pixels, res};
      stack_len = 0;
      dropped = 0;
      for (int i = 0; i < MaxFrames; i++) keep_px[i] = 0;
    end
  endtask

  // Input driver: hold until accepted, then advance or idle
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(1, 16);
        in_valid_i <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_data_i <= pending_items.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output ready: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin
    if (long_hold_req) begin
      long_hold_req <= 1'b0;
      hold_cnt <= LongHold;
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      recv_gap <= $urandom_range(1, 16);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: predict on accepted input, check accepted results
  always @(posedge clk_i) begin
    out_t exp_px;
    in_fire <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) combine_item(in_data_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data_o);
        end else begin
          exp_px = expected_pixels.pop_front();
          if (out_data_o.pixel_value !== exp_px.pixel_value ||
              out_data_o.kept_count !== exp_px.kept_count ||
              out_data_o.overflow !== exp_px.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", exp_px, out_data_o);
          end
        end
      end
    end
  end

  // Watchdog: count cycles with no accepted item on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [11:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgMethod:  method_q = data[1:0];
      CfgSigma:   sigma_q = data;
      CfgWeights: weights_on_q = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Wait until every queued item is sent and every expected result has come, then let the block settle
  task automatic drain();
    @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic push_px(input logic [15:0] px, input logic [15:0] wt, input bit last);
    in_t it;
    it.sample = px;
    it.frame_weight = wt;
    it.last_sample = last;
    pending_items = {pending_items, it};
  endtask

  // Queue one random stack; kind picks the sample pattern
  task automatic push_stack(output int unsigned n);
    int unsigned kind, wkind;
    logic [15:0] base, px, wt;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 8);
    kind = $urandom_range(0, 3);
    wkind = $urandom_range(0, 5);
    base = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: px = 16'($urandom);
        1: px = ($urandom_range(0, 5) == 0) ? 16'($urandom) : base + 16'($urandom_range(0, 40));
        2: px = base;
        default: px = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      endcase
      case (wkind)
        0: wt = 16'h0000;
        1: wt = 16'hFFFF;
        2: wt = 16'h0100;
        default: wt = 16'($urandom);
      endcase
      push_px(px, wt, i == n - 1);
    end
  endtask

  initial begin
    int unsigned n, total;
    logic [1:0]  methods [7] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3, 2'd0};
    logic [11:0] sigmas  [7] = '{12'd768, 12'd100, 12'd768, 12'd0, 12'd4095, 12'd256, 12'd512};
    logic        weights [7] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgMethod;
    cfg_data_i = '0;
    method_q = MethodClip;
    sigma_q = 12'd768;
    weights_on_q = 1'b0;
    stack_len = 0;
    dropped = 0;
    mismatches = 0;
    quiet = 0;
    long_hold_req = 0;
    send_gap = 0;
    recv_gap = 0;
    hold_cnt = 0;
    idle_cycles = 0;
    for (int i = 0; i < MaxFrames; i++) keep_px[i] = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: clipping with weights on
    write_reg(CfgWeights, 12'd1);
    write_reg(CfgNone, 12'hABC);
    push_px(16'd100, 16'd256, 0); push_px(16'd100, 16'd9, 0); push_px(16'd100, 16'd1, 1);
    push_px(16'hFFFF, 16'hFFFF, 1);
    push_px(16'd5, 16'd0, 0); push_px(16'd9, 16'd0, 0); push_px(16'd70, 16'd0, 1);
    push_px(16'd1000, 16'd256, 0); push_px(16'd1001, 16'd256, 0); push_px(16'd999, 16'd256, 0);
    push_px(16'd1000, 16'd256, 0); push_px(16'd60000, 16'd256, 1);
    drain();
    // Directed: median through a wide register value, then mean at the extremes
    write_reg(CfgMethod, 12'hFFD);
    push_px(16'd7, 16'd1, 0); push_px(16'd3, 16'd1, 0); push_px(16'd3, 16'd1, 0);
    push_px(16'd0, 16'd1, 1);
    drain();
    write_reg(CfgMethod, 12'd0);
    push_px(16'hFFFF, 16'hFFFF, 0); push_px(16'h0000, 16'hFFFF, 0); push_px(16'hFFFF, 16'd1, 1);
    drain();

    // Random phases over several register settings
    for (int p = 0; p < 8; p++) begin
      if (p == 7) quiet = 1;
      write_reg(CfgMethod, {10'($urandom), methods[p % 7]});
      write_reg(CfgSigma, sigmas[p % 7]);
      write_reg(CfgWeights, {11'($urandom), weights[p % 7]});
      if (p == 2) long_hold_req = 1;
      total = 0;
      while (total < 250) begin
        push_stack(n);
        total += n;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/psc_pkg.sv
rtl/pixel_stack_combiner_core.sv
tb/tb_top.sv
